// ===== hdl/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
package tcw_pkg;

    // Geometry defaults.
    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int MEM_WORDS_DEF = 8192;

    // Fixed field widths.
    localparam int ADDR_W    = 13;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int WORD_W    = 16;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 48;

    // Register reset values.
    localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h07;
    localparam logic [WORD_W-1:0] BLANK_RESET = 16'h0720;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 1'b1;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_CHAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    typedef enum logic [2:0] {
        CC_IGNORE,
        CC_BS,
        CC_LF,
        CC_FF,
        CC_CR,
        CC_DEL,
        CC_PRINT
    } char_class_t;

    // Datapath register operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RADDR_REDUCE,
        OP_CLR_INIT,
        OP_FILL_ADV,
        OP_BS_STEP,
        OP_CR_STEP,
        OP_WRAP_STEP,
        OP_ROW_DOWN,
        OP_COPY_INIT,
        OP_COPY_ADV,
        OP_COPY_END,
        OP_ERASE_INIT,
        OP_SCROLL_END,
        OP_PRINT_ADV,
        OP_OUT_LOAD
    } dp_op_t;

    typedef enum logic [1:0] {
        ADDR_PTR,
        ADDR_SRC,
        ADDR_CUR,
        ADDR_RADDR
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_BLANK,
        WD_CHAR,
        WD_COPY
    } wd_sel_t;

    typedef struct packed {
        logic      load_req;
        logic      mem_we;
        logic      mem_re;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        dp_op_t    op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        char_class_t      cclass;
        logic             col_zero;
        logic             col_full;
        logic             row_last;
        logic             need_copy;
        logic             raddr_ge;
        logic             ptr_last;
        logic             cnt_col_last;
        logic             cnt_scr_last;
        logic             out_free;
    } dp_status_t;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] ch);
        char_class_t c;
        case (ch)
            CH_NUL, CH_BEL, CH_HT, CH_VT, CH_ESC: c = CC_IGNORE;
            CH_BS:   c = CC_BS;
            CH_LF:   c = CC_LF;
            CH_FF:   c = CC_FF;
            CH_CR:   c = CC_CR;
            CH_DEL:  c = CC_DEL;
            default: c = CC_PRINT;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/tcw_ctrl.sv =====
// Sequencer for the text console writer: decodes requests and walks memory sweeps.
module tcw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  tcw_pkg::dp_status_t    status,
    output tcw_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [19:0] {
        ST_IDLE       = 20'h00001,
        ST_DECODE     = 20'h00002,
        ST_RD_WRAP    = 20'h00004,
        ST_RD_ISSUE   = 20'h00008,
        ST_CLR_INIT   = 20'h00010,
        ST_CLR_FILL   = 20'h00020,
        ST_BS_STEP    = 20'h00040,
        ST_BLANK_WR   = 20'h00080,
        ST_CR_STEP    = 20'h00100,
        ST_WRAP_STEP  = 20'h00200,
        ST_LF         = 20'h00400,
        ST_COPY_INIT  = 20'h00800,
        ST_COPY_RD    = 20'h01000,
        ST_COPY_WR    = 20'h02000,
        ST_COPY_END   = 20'h04000,
        ST_ERASE_INIT = 20'h08000,
        ST_ERASE      = 20'h10000,
        ST_SCROLL_END = 20'h20000,
        ST_PRINT      = 20'h40000,
        ST_FINISH     = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    state_t after_lf;

    // Where a line feed continues, by the character that caused it.
    always_comb
    begin
        case (status.cclass)
            tcw_pkg::CC_LF:    after_lf = ST_CR_STEP;
            tcw_pkg::CC_PRINT: after_lf = ST_PRINT;
            default:           after_lf = ST_FINISH;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.mem_we   = 1'b0;
        cmd.mem_re   = 1'b0;
        cmd.addr_sel = tcw_pkg::ADDR_PTR;
        cmd.wd_sel   = tcw_pkg::WD_BLANK;
        cmd.op       = tcw_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.req_type)
                    tcw_pkg::REQ_CHAR:
                    begin
                        case (status.cclass)
                            tcw_pkg::CC_BS:
                                state_next = status.col_zero ? ST_FINISH : ST_BS_STEP;
                            tcw_pkg::CC_LF, tcw_pkg::CC_FF:
                                state_next = ST_LF;
                            tcw_pkg::CC_CR:
                                state_next = ST_CR_STEP;
                            tcw_pkg::CC_DEL:
                                state_next = ST_BLANK_WR;
                            tcw_pkg::CC_PRINT:
                                state_next = status.col_full ? ST_WRAP_STEP : ST_PRINT;
                            default:
                                state_next = ST_FINISH;
                        endcase
                    end
                    tcw_pkg::REQ_READ:  state_next = ST_RD_WRAP;
                    tcw_pkg::REQ_CLEAR: state_next = ST_CLR_INIT;
                    default:            state_next = ST_FINISH;
                endcase
            end
            ST_RD_WRAP:
            begin
                if (status.raddr_ge)
                    cmd.op = tcw_pkg::OP_RADDR_REDUCE;
                else
                    state_next = ST_RD_ISSUE;
            end
            ST_RD_ISSUE:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_RADDR;
                state_next   = ST_FINISH;
            end
            ST_CLR_INIT:
            begin
                cmd.op     = tcw_pkg::OP_CLR_INIT;
                state_next = ST_CLR_FILL;
            end
            ST_CLR_FILL:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_PTR;
                cmd.wd_sel   = tcw_pkg::WD_BLANK;
                cmd.op       = tcw_pkg::OP_FILL_ADV;
                if (status.ptr_last)
                    state_next = ST_FINISH;
            end
            ST_BS_STEP:
            begin
                cmd.op     = tcw_pkg::OP_BS_STEP;
                state_next = ST_BLANK_WR;
            end
            ST_BLANK_WR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_CUR;
                cmd.wd_sel   = tcw_pkg::WD_BLANK;
                state_next   = ST_FINISH;
            end
            ST_CR_STEP:
            begin
                cmd.op     = tcw_pkg::OP_CR_STEP;
                state_next = ST_FINISH;
            end
            ST_WRAP_STEP:
            begin
                cmd.op     = tcw_pkg::OP_WRAP_STEP;
                state_next = ST_LF;
            end
            ST_LF:
            begin
                if (!status.row_last)
                begin
                    cmd.op     = tcw_pkg::OP_ROW_DOWN;
                    state_next = after_lf;
                end
                else if (status.need_copy)
                    state_next = ST_COPY_INIT;
                else
                    state_next = ST_ERASE_INIT;
            end
            ST_COPY_INIT:
            begin
                cmd.op     = tcw_pkg::OP_COPY_INIT;
                state_next = ST_COPY_RD;
            end
            ST_COPY_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_SRC;
                state_next   = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_PTR;
                cmd.wd_sel   = tcw_pkg::WD_COPY;
                cmd.op       = tcw_pkg::OP_COPY_ADV;
                state_next   = status.cnt_scr_last ? ST_COPY_END : ST_COPY_RD;
            end
            ST_COPY_END:
            begin
                cmd.op     = tcw_pkg::OP_COPY_END;
                state_next = ST_ERASE_INIT;
            end
            ST_ERASE_INIT:
            begin
                cmd.op     = tcw_pkg::OP_ERASE_INIT;
                state_next = ST_ERASE;
            end
            ST_ERASE:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_PTR;
                cmd.wd_sel   = tcw_pkg::WD_BLANK;
                cmd.op       = tcw_pkg::OP_FILL_ADV;
                if (status.cnt_col_last)
                    state_next = ST_SCROLL_END;
            end
            ST_SCROLL_END:
            begin
                cmd.op     = tcw_pkg::OP_SCROLL_END;
                state_next = after_lf;
            end
            ST_PRINT:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = tcw_pkg::ADDR_CUR;
                cmd.wd_sel   = tcw_pkg::WD_CHAR;
                cmd.op       = tcw_pkg::OP_PRINT_ADV;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tcw_pkg::OP_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/tcw_dp.sv =====
// Datapath for the text console writer: cursor state, video memory and result register.
module tcw_dp #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int MEM_WORDS = tcw_pkg::MEM_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcw_pkg::ctrl_cmd_t                  cmd,
    output tcw_pkg::dp_status_t                 status,
    input  logic                                cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]           cfg_data,
    input  logic [tcw_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic [tcw_pkg::REQ_W-1:0]           s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser
);

    localparam int AW         = tcw_pkg::ADDR_W;
    localparam int MAW        = $clog2(MEM_WORDS);
    localparam int SCREEN     = COLUMNS * ROWS;
    localparam int SCREEN_MOD = SCREEN % MEM_WORDS;
    localparam int CNT_W      = $clog2(SCREEN);
    localparam int PAD_W      = tcw_pkg::M_DATA_W - 2 * AW - tcw_pkg::WORD_W;

    localparam logic [AW:0]   MEM_X   = (AW + 1)'(MEM_WORDS);
    localparam logic [AW-1:0] LAST_A  = AW'(MEM_WORDS - 1);
    localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
    localparam logic [AW-1:0] SMOD_A  = AW'(SCREEN_MOD);
    localparam logic [AW:0]   SCRL_X  = (AW + 1)'(SCREEN + COLUMNS);

    function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MEM_X)
            s = s - MEM_X;
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b)
            s = {1'b0, a} - {1'b0, b};
        else
            s = {1'b0, a} + MEM_X - {1'b0, b};
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == LAST_A) ? '0 : a + AW'(1);
    endfunction

    // Configuration
    logic [tcw_pkg::CHAR_W-1:0] attr_reg;
    logic [tcw_pkg::WORD_W-1:0] blank_reg;

    // Console state
    logic [AW-1:0]              ss_reg, ss_next;
    logic [AW-1:0]              cur_reg, cur_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;

    // Request and sweep registers
    logic [tcw_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [tcw_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic [AW-1:0]              raddr_reg, raddr_next;
    logic                       eot_reg, eot_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [AW-1:0]              src_reg, src_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // Result register
    logic                       ovalid_reg, ovalid_next;
    logic [AW-1:0]              ostart_reg, ostart_next;
    logic [AW-1:0]              ocur_reg, ocur_next;
    logic                       oupd_reg, oupd_next;
    logic [tcw_pkg::WORD_W-1:0] ordata_reg, ordata_next;

    // Video memory
    logic [tcw_pkg::WORD_W-1:0] mem [MEM_WORDS];
    logic [tcw_pkg::WORD_W-1:0] mem_q;
    logic [AW-1:0]              mem_addr;
    logic [tcw_pkg::WORD_W-1:0] mem_wd;

    always_comb
    begin
        case (cmd.addr_sel)
            tcw_pkg::ADDR_PTR:   mem_addr = ptr_reg;
            tcw_pkg::ADDR_SRC:   mem_addr = src_reg;
            tcw_pkg::ADDR_CUR:   mem_addr = cur_reg;
            tcw_pkg::ADDR_RADDR: mem_addr = raddr_reg;
            default:             mem_addr = ptr_reg;
        endcase
        case (cmd.wd_sel)
            tcw_pkg::WD_BLANK: mem_wd = blank_reg;
            tcw_pkg::WD_CHAR:  mem_wd = {attr_reg, ch_reg};
            tcw_pkg::WD_COPY:  mem_wd = mem_q;
            default:           mem_wd = blank_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[mem_addr[MAW-1:0]] <= mem_wd;
        if (cmd.mem_re)
            mem_q <= mem[mem_addr[MAW-1:0]];
    end

    // Status to the sequencer
    always_comb
    begin
        status.req_type     = req_reg;
        status.cclass       = tcw_pkg::classify(ch_reg);
        status.col_zero     = (col_reg == '0);
        status.col_full     = (col_reg >= tcw_pkg::COL_W'(COLUMNS));
        status.row_last     = (row_reg == tcw_pkg::ROW_W'(ROWS - 1));
        status.need_copy    = (({1'b0, ss_reg} + SCRL_X) >= MEM_X);
        status.raddr_ge     = ({1'b0, raddr_reg} >= MEM_X);
        status.ptr_last     = (ptr_reg == LAST_A);
        status.cnt_col_last = (cnt_reg == CNT_W'(COLUMNS - 1));
        status.cnt_scr_last = (cnt_reg == CNT_W'(SCREEN - 1));
        status.out_free     = !ovalid_reg || m_tready;
    end

    always_comb
    begin
        ss_next     = ss_reg;
        cur_next    = cur_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        req_next    = req_reg;
        ch_next     = ch_reg;
        raddr_next  = raddr_reg;
        eot_next    = eot_reg;
        ptr_next    = ptr_reg;
        src_next    = src_reg;
        cnt_next    = cnt_reg;
        ostart_next = ostart_reg;
        ocur_next   = ocur_reg;
        oupd_next   = oupd_reg;
        ordata_next = ordata_reg;
        ovalid_next = ovalid_reg && !m_tready;

        if (cmd.load_req)
        begin
            req_next   = s_tuser;
            ch_next    = s_tdata[7:0];
            raddr_next = s_tdata[8 +: AW];
            eot_next   = s_tlast;
        end

        case (cmd.op)
            tcw_pkg::OP_RADDR_REDUCE:
                raddr_next = raddr_reg - MEM_X[AW-1:0];
            tcw_pkg::OP_CLR_INIT:
            begin
                ss_next  = '0;
                cur_next = '0;
                col_next = '0;
                row_next = '0;
                ptr_next = '0;
            end
            tcw_pkg::OP_FILL_ADV:
            begin
                ptr_next = inc_wrap(ptr_reg);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            tcw_pkg::OP_BS_STEP:
            begin
                col_next = col_reg - tcw_pkg::COL_W'(1);
                cur_next = sub_mod(cur_reg, AW'(1));
            end
            tcw_pkg::OP_CR_STEP:
            begin
                cur_next = sub_mod(cur_reg, AW'(col_reg));
                col_next = '0;
            end
            tcw_pkg::OP_WRAP_STEP:
            begin
                col_next = col_reg - tcw_pkg::COL_W'(COLUMNS);
                cur_next = sub_mod(cur_reg, COLS_A);
            end
            tcw_pkg::OP_ROW_DOWN:
            begin
                row_next = row_reg + tcw_pkg::ROW_W'(1);
                cur_next = add_mod(cur_reg, COLS_A);
            end
            tcw_pkg::OP_COPY_INIT:
            begin
                ptr_next = '0;
                src_next = ss_reg;
                cnt_next = '0;
            end
            tcw_pkg::OP_COPY_ADV:
            begin
                ptr_next = inc_wrap(ptr_reg);
                src_next = inc_wrap(src_reg);
                cnt_next = cnt_reg + CNT_W'(1);
            end
            tcw_pkg::OP_COPY_END:
            begin
                cur_next = sub_mod(cur_reg, ss_reg);
                ss_next  = '0;
            end
            tcw_pkg::OP_ERASE_INIT:
            begin
                ptr_next = add_mod(ss_reg, SMOD_A);
                cnt_next = '0;
            end
            tcw_pkg::OP_SCROLL_END:
            begin
                ss_next  = add_mod(ss_reg, COLS_A);
                cur_next = add_mod(cur_reg, COLS_A);
            end
            tcw_pkg::OP_PRINT_ADV:
            begin
                cur_next = inc_wrap(cur_reg);
                col_next = col_reg + tcw_pkg::COL_W'(1);
            end
            tcw_pkg::OP_OUT_LOAD:
            begin
                ovalid_next = 1'b1;
                ostart_next = ss_reg;
                ocur_next   = cur_reg;
                case (req_reg)
                    tcw_pkg::REQ_CHAR:  oupd_next = eot_reg;
                    tcw_pkg::REQ_CLEAR: oupd_next = 1'b1;
                    default:            oupd_next = 1'b0;
                endcase
                ordata_next = (req_reg == tcw_pkg::REQ_READ) ? mem_q : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg   <= tcw_pkg::ATTR_RESET;
            blank_reg  <= tcw_pkg::BLANK_RESET;
            ss_reg     <= '0;
            cur_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == tcw_pkg::CFG_ATTR)
                attr_reg <= cfg_data[tcw_pkg::CHAR_W-1:0];
            if (cfg_we && cfg_index == tcw_pkg::CFG_BLANK)
                blank_reg <= cfg_data;
            ss_reg     <= ss_next;
            cur_reg    <= cur_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        ch_reg     <= ch_next;
        raddr_reg  <= raddr_next;
        eot_reg    <= eot_next;
        ptr_reg    <= ptr_next;
        src_reg    <= src_next;
        cnt_reg    <= cnt_next;
        ostart_reg <= ostart_next;
        ocur_reg   <= ocur_next;
        oupd_reg   <= oupd_next;
        ordata_reg <= ordata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, ordata_reg, ocur_reg, ostart_reg};
    assign m_tuser  = oupd_reg;

endmodule

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: sequencer plus datapath.
//
// Console engine owning a video word memory of MEM_WORDS words. The slave
// stream takes one request per item (print a character byte, read a video
// word, clear the memory); the master stream returns one result item per
// request: screen start, cursor address, cursor-update flag, read data.
// cfg_we writes cfg_data into register cfg_index (0 attribute byte, 1 blank
// word) at the clock edge; write only while the block is idle.
// Each request finishes before the next is taken (one memory access per
// cycle). A character or control code without scroll writes at most one
// word; a line feed or wrap that scrolls erases the row below the screen,
// first copying the screen to word 0 if it would run past the memory end;
// a read subtracts MEM_WORDS from the address while it is at least
// MEM_WORDS, then reads; a clear writes the blank word to all MEM_WORDS words.
// The next item is taken once the result sits in the output register,
// even while the receiver stalls; a stalled result holds its payload and
// the next result waits behind it. Reset clears cursor, row, column,
// screen start and result valid, loads the attribute and blank defaults;
// the memory is undefined until the first clear request.
module text_console_writer #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS      = tcw_pkg::ROWS_DEF,
    parameter int MEM_WORDS = tcw_pkg::MEM_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]          cfg_data,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tcw_pkg::S_DATA_W-1:0]       s_tdata,  // [7:0] char_code, [20:8] read_addr
    input  logic [tcw_pkg::REQ_W-1:0]          s_tuser,  // [1:0] req_type
    input  logic                               s_tlast,  // end_of_text
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]       m_tdata,  // [12:0] start_addr,
                                                         // [25:13] cursor_addr,
                                                         // [41:26] read_data
    output logic                               m_tuser   // [0] cursor_update
);

    tcw_pkg::ctrl_cmd_t  cmd;
    tcw_pkg::dp_status_t status;

    // request decode and memory sweep sequencing
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // console state, address arithmetic, video memory, result register
    tcw_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== verif/text_console_writer_test.sv =====
// Self-checking testbench for text_console_writer: request stream against a behavioral console model.
`timescale 1ns / 1ps

module text_console_writer_test;
    import tcw_pkg::*;

    // Geometry of the instance under test (package defaults).
    localparam int COLS     = COLUMNS_DEF;
    localparam int ROWS_N   = ROWS_DEF;
    localparam int MEM_N    = MEM_WORDS_DEF;
    localparam int SCREEN_N = COLS * ROWS_N;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;  // no-op request kind

    localparam int DIR_N       = 24;         // directed rows
    localparam int PHASES      = 8;          // register settings in the random part
    localparam int RAND_ITEMS  = 2000;
    localparam int SETTLE      = 20;         // idle cycles before a register write / the end
    localparam int CYCLE_LIMIT = 3_000_000;

    // One result item as seen on the master stream.
    typedef struct packed {
        logic [ADDR_W-1:0] start_a;
        logic [ADDR_W-1:0] cursor_a;
        logic              upd;
        logic [WORD_W-1:0] rdata;
    } console_res_t;

    // One request item; 'typed' rows carry a hand-written expectation.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic              eot;
        logic              typed;
        console_res_t      want;
    } req_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // [7:0] char_code, [20:8] read_addr
    logic [REQ_W-1:0]    s_tuser   = '0;  // [1:0] req_type
    logic                s_tlast   = 1'b0; // end_of_text
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // [12:0] start_addr, [25:13] cursor_addr, [41:26] read_data
    logic                m_tuser;  // [0] cursor_update

    text_console_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Console model state: video memory, screen start, cursor, row/column
    // and the two registers.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] vram [MEM_N];
    int                scr_start = 0;
    int                cur_word  = 0;
    int                col       = 0;
    int                row_idx   = 0;
    logic [CHAR_W-1:0] attr_reg  = ATTR_RESET;
    logic [WORD_W-1:0] blank_reg = BLANK_RESET;

    console_res_t expected_reports [$];

    int errors    = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_reads   = 0;
    int n_clears  = 0;
    int n_scrolls = 0;
    int n_copies  = 0;
    int cycle_cnt = 0;

    bit quiet_tail  = 1'b0;  // no idling on either side in the last phase
    bit send_bursty = 1'b1;
    bit recv_calm   = 1'b0;
    int stall_left  = 0;

    function automatic req_row_t req_row(input logic [REQ_W-1:0] req,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic eot,
                                         input logic typed,
                                         input logic [ADDR_W-1:0] s_a,
                                         input logic [ADDR_W-1:0] c_a,
                                         input logic upd,
                                         input logic [WORD_W-1:0] rd);
        req_row_t r;
        r.req           = req;
        r.ch            = ch;
        r.addr          = addr;
        r.eot           = eot;
        r.typed         = typed;
        r.want.start_a  = s_a;
        r.want.cursor_a = c_a;
        r.want.upd      = upd;
        r.want.rdata    = rd;
        return r;
    endfunction

    // Line feed: next row, or scroll on the bottom row. A scroll that would
    // run past the memory end first moves the visible screen down to word 0.
    function automatic void advance_line();
        int i;
        if (row_idx + 1 < ROWS_N)
        begin
            row_idx++;
            cur_word = (cur_word + COLS) % MEM_N;
        end
        else
        begin
            n_scrolls++;
            if (scr_start + SCREEN_N + COLS >= MEM_N)
            begin
                n_copies++;
                for (i = 0; i < SCREEN_N; i++)
                    vram[i] = vram[(scr_start + i) % MEM_N];
                cur_word  = (cur_word + MEM_N - scr_start) % MEM_N;
                scr_start = 0;
            end
            // erase the row just below the screen
            for (i = 0; i < COLS; i++)
                vram[(scr_start + SCREEN_N + i) % MEM_N] = blank_reg;
            scr_start = (scr_start + COLS) % MEM_N;
            cur_word  = (cur_word + COLS) % MEM_N;
        end
    endfunction

    function automatic void return_carriage();
        cur_word = (cur_word + MEM_N - col) % MEM_N;
        col      = 0;
    endfunction

    // Apply one accepted request to the model, return the result it reports.
    function automatic console_res_t console_apply(input req_row_t r);
        console_res_t res;
        int           i;
        res = '0;
        case (r.req)
            REQ_CHAR:
            begin
                case (r.ch)
                    CH_NUL, CH_BEL, CH_HT, CH_VT, CH_ESC: ;
                    CH_BS:
                    begin
                        // nothing at column zero
                        if (col != 0)
                        begin
                            col--;
                            cur_word = (cur_word + MEM_N - 1) % MEM_N;
                            vram[cur_word] = blank_reg;
                        end
                    end
                    CH_LF:
                    begin
                        advance_line();
                        return_carriage();
                    end
                    CH_FF:  advance_line();
                    CH_CR:  return_carriage();
                    CH_DEL: vram[cur_word] = blank_reg;
                    default:
                    begin
                        // wrap at the column limit before printing
                        if (col >= COLS)
                        begin
                            col -= COLS;
                            cur_word = (cur_word + MEM_N - COLS) % MEM_N;
                            advance_line();
                        end
                        vram[cur_word] = {attr_reg, r.ch};
                        cur_word = (cur_word + 1) % MEM_N;
                        col++;
                    end
                endcase
                res.upd = r.eot;
            end
            REQ_READ:
            begin
                n_reads++;
                res.rdata = vram[r.addr % MEM_N];
            end
            REQ_CLEAR:
            begin
                n_clears++;
                scr_start = 0;
                cur_word  = 0;
                col       = 0;
                row_idx   = 0;
                for (i = 0; i < MEM_N; i++)
                    vram[i] = blank_reg;
                res.upd = 1'b1;
            end
            default: ;
        endcase
        res.start_a  = ADDR_W'(scr_start);
        res.cursor_a = ADDR_W'(cur_word);
        return res;
    endfunction

    // Random printable byte (control codes folded into 0x20..0x5F).
    function automatic logic [CHAR_W-1:0] rand_glyph();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        case (c)
            CH_NUL, CH_BEL, CH_BS, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR, CH_ESC, CH_DEL:
                c = 8'h20 + {2'b00, c[5:0]};
            default: ;
        endcase
        return c;
    endfunction

    // Drive one item, hold it until accepted, then predict its result.
    // Leaves s_tvalid high so back-to-back items need no extra edge.
    task automatic send_item(input req_row_t r);
        console_res_t want;
        int           gap;
        gap = 0;
        if (!quiet_tail && send_bursty && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req;
        s_tlast  <= r.eot;
        s_tdata  <= {{(S_DATA_W - ADDR_W - CHAR_W){1'b0}}, r.addr, r.ch};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        want = console_apply(r);
        if (r.typed)
            want = r.want;
        expected_reports.push_back(want);
        n_sent++;
    endtask

    // Stop sending, let every outstanding result drain, then idle a little.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: compare each accepted item with the oldest expectation,
    // and stall m_tready in random bursts.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        console_res_t got;
        console_res_t want;
        logic         ready_n;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.start_a  = m_tdata[12:0];
                got.cursor_a = m_tdata[25:13];
                got.rdata    = m_tdata[41:26];
                got.upd      = m_tuser;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got start %0d cursor %0d upd %0b rd %h",
                             $time, got.start_a, got.cursor_a, got.upd, got.rdata);
                    errors++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    n_checked++;
                    if (got.start_a !== want.start_a)
                    begin
                        $display("%0t: start_addr expected %0d got %0d",
                                 $time, want.start_a, got.start_a);
                        errors++;
                    end
                    if (got.cursor_a !== want.cursor_a)
                    begin
                        $display("%0t: cursor_addr expected %0d got %0d",
                                 $time, want.cursor_a, got.cursor_a);
                        errors++;
                    end
                    if (got.upd !== want.upd)
                    begin
                        $display("%0t: cursor_update expected %0b got %0b",
                                 $time, want.upd, got.upd);
                        errors++;
                    end
                    if (got.rdata !== want.rdata)
                    begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.rdata, got.rdata);
                        errors++;
                    end
                end
            end

            // receiver idling: stall bursts whose length stall_left counts down, with calm stretches
            if ($urandom_range(0, 255) == 0)
                recv_calm = !recv_calm;
            if (quiet_tail)
                ready_n = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_n = 1'b0;
            end
            else if (!recv_calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                ready_n    = 1'b0;
            end
            else
                ready_n = 1'b1;
            m_tready <= ready_n;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_reports.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        req_row_t          dir_tab [DIR_N];
        logic [CHAR_W-1:0] attr_v;
        logic [WORD_W-1:0] blank_v;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] ra;
        int                k;
        int                p;
        int                j;
        int                seq_len;
        int                pick;
        int                phase_end;

        // Directed part. Memory is undefined until cleared, so the clear
        // comes first and every later read hits written words.
        dir_tab[0]  = req_row(REQ_CLEAR,  8'h00, 13'd0,    1'b0, 1'b1, 13'd0, 13'd0, 1'b1, 16'h0);
        dir_tab[1]  = req_row(REQ_READ,   8'h00, 13'd0,    1'b0, 1'b1, 13'd0, 13'd0, 1'b0, BLANK_RESET);
        dir_tab[2]  = req_row(REQ_READ,   8'hFF, 13'd8191, 1'b1, 1'b1, 13'd0, 13'd0, 1'b0, BLANK_RESET);
        dir_tab[3]  = req_row(REQ_CHAR,   8'h41, 13'd0,    1'b1, 1'b1, 13'd0, 13'd1, 1'b1, 16'h0);
        dir_tab[4]  = req_row(REQ_READ,   8'h00, 13'd0,    1'b0, 1'b1, 13'd0, 13'd1, 1'b0, 16'h0741);
        dir_tab[5]  = req_row(REQ_CHAR,   8'hFF, 13'd8191, 1'b0, 1'b1, 13'd0, 13'd2, 1'b0, 16'h0);
        dir_tab[6]  = req_row(REQ_CHAR,   8'h80, 13'd0,    1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[7]  = req_row(REQ_CHAR,   CH_BS, 13'd0,    1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[8]  = req_row(REQ_CHAR,   CH_DEL, 13'd0,   1'b1, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[9]  = req_row(REQ_CHAR,   CH_CR, 13'd0,    1'b0, 1'b1, 13'd0, 13'd0, 1'b0, 16'h0);
        // backspace at column zero does nothing
        dir_tab[10] = req_row(REQ_CHAR,   CH_BS, 13'd0,    1'b0, 1'b1, 13'd0, 13'd0, 1'b0, 16'h0);
        // ignored control codes
        dir_tab[11] = req_row(REQ_CHAR,   CH_NUL, 13'd0,   1'b1, 1'b1, 13'd0, 13'd0, 1'b1, 16'h0);
        dir_tab[12] = req_row(REQ_CHAR,   CH_BEL, 13'd0,   1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[13] = req_row(REQ_CHAR,   CH_HT, 13'd0,    1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[14] = req_row(REQ_CHAR,   CH_VT, 13'd0,    1'b1, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[15] = req_row(REQ_CHAR,   CH_ESC, 13'd0,   1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[16] = req_row(REQ_CHAR,   CH_LF, 13'd0,    1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[17] = req_row(REQ_CHAR,   CH_FF, 13'd0,    1'b1, 1'b0, '0, '0, 1'b0, '0);
        // unused request kind changes nothing
        dir_tab[18] = req_row(REQ_UNUSED, 8'hFF, 13'd8191, 1'b1, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[19] = req_row(REQ_READ,   8'h00, 13'd80,   1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[20] = req_row(REQ_CHAR,   8'h20, 13'd4096, 1'b1, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[21] = req_row(REQ_CHAR,   CH_DEL, 13'd0,   1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[22] = req_row(REQ_READ,   8'h00, 13'd8191, 1'b0, 1'b0, '0, '0, 1'b0, '0);
        dir_tab[23] = req_row(REQ_CLEAR,  8'hFF, 13'd8191, 1'b1, 1'b1, 13'd0, 13'd0, 1'b1, 16'h0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_N; k++)
            send_item(dir_tab[k]);

        // Random part in phases, each with its own register setting.
        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    attr_v  = 8'h00;
                    blank_v = 16'hFFFF;
                end
                1:
                begin
                    attr_v  = 8'hFF;
                    blank_v = 16'h0000;
                end
                2:
                begin
                    attr_v  = ATTR_RESET;
                    blank_v = BLANK_RESET;
                end
                default:
                begin
                    attr_v  = CHAR_W'($urandom_range(0, 255));
                    blank_v = WORD_W'($urandom_range(0, 65535));
                end
            endcase
            // upper byte of the attribute write is don't-care
            cfg_we    <= 1'b1;
            cfg_index <= CFG_ATTR;
            cfg_data  <= {CHAR_W'($urandom_range(0, 255)), attr_v};
            @(posedge clk);
            attr_reg   = attr_v;
            cfg_index <= CFG_BLANK;
            cfg_data  <= blank_v;
            @(posedge clk);
            blank_reg  = blank_v;
            cfg_we    <= 1'b0;

            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            if (p < 3 || $urandom_range(0, 1) == 0)
                send_item(req_row(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                  ADDR_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                                  1'b0, '0, '0, 1'b0, '0));

            phase_end = n_sent + RAND_ITEMS / PHASES;
            while (n_sent < phase_end)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_bursty = !send_bursty;
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // text line: mostly short, some long enough to wrap
                    seq_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                         : $urandom_range(60, 170);
                    for (j = 0; j < seq_len; j++)
                    begin
                        ch = ($urandom_range(0, 15) == 0) ? CH_BS : rand_glyph();
                        send_item(req_row(REQ_CHAR, ch, ADDR_W'($urandom_range(0, 8191)),
                                          1'($urandom_range(0, 7) == 0), 1'b0,
                                          '0, '0, 1'b0, '0));
                    end
                    case ($urandom_range(0, 3))
                        0: send_item(req_row(REQ_CHAR, CH_LF, '0, 1'b1, 1'b0, '0, '0, 1'b0, '0));
                        1:
                        begin
                            send_item(req_row(REQ_CHAR, CH_CR, '0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
                            send_item(req_row(REQ_CHAR, CH_LF, '0, 1'b1, 1'b0, '0, '0, 1'b0, '0));
                        end
                        2: send_item(req_row(REQ_CHAR, CH_FF, '0, 1'b1, 1'b0, '0, '0, 1'b0, '0));
                        default:
                            send_item(req_row(REQ_CHAR, CH_CR, '0, 1'b1, 1'b0, '0, '0, 1'b0, '0));
                    endcase
                end
                else if (pick < 53)
                begin
                    // run of line feeds: drives scrolling up to the memory end
                    seq_len = $urandom_range(20, 120);
                    for (j = 0; j < seq_len; j++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            ch = rand_glyph();
                        else
                            ch = ($urandom_range(0, 3) == 0) ? CH_FF : CH_LF;
                        send_item(req_row(REQ_CHAR, ch, ADDR_W'($urandom_range(0, 8191)),
                                          1'(j == seq_len - 1), 1'b0, '0, '0, 1'b0, '0));
                    end
                end
                else if (pick < 66)
                begin
                    case ($urandom_range(0, 9))
                        0: ch = CH_NUL;
                        1: ch = CH_BEL;
                        2: ch = CH_BS;
                        3: ch = CH_HT;
                        4: ch = CH_LF;
                        5: ch = CH_VT;
                        6: ch = CH_FF;
                        7: ch = CH_CR;
                        8: ch = CH_ESC;
                        default: ch = CH_DEL;
                    endcase
                    send_item(req_row(REQ_CHAR, ch, ADDR_W'($urandom_range(0, 8191)),
                                      1'($urandom_range(0, 1)), 1'b0, '0, '0, 1'b0, '0));
                end
                else if (pick < 82)
                begin
                    // reads: anywhere, the memory ends, or near the cursor
                    case ($urandom_range(0, 3))
                        0: ra = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'd8191;
                        1: ra = ADDR_W'(cur_word + MEM_N - 1 - $urandom_range(0, 3));
                        default: ra = ADDR_W'($urandom_range(0, 8191));
                    endcase
                    send_item(req_row(REQ_READ, CHAR_W'($urandom_range(0, 255)), ra,
                                      1'($urandom_range(0, 1)), 1'b0, '0, '0, 1'b0, '0));
                end
                else if (pick < 87)
                    send_item(req_row(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)),
                                      ADDR_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                                      1'b0, '0, '0, 1'b0, '0));
                else if (pick < 99)
                    send_item(req_row(REQ_CHAR, CHAR_W'($urandom_range(0, 255)),
                                      ADDR_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                                      1'b0, '0, '0, 1'b0, '0));
                else
                    send_item(req_row(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                      ADDR_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                                      1'b0, '0, '0, 1'b0, '0));
            end
        end

        wait_drained();

        $display("Covered %0d requests (%0d reads, %0d clears), %0d results compared",
                 n_sent, n_reads, n_clears, n_checked);
        $display("  %0d scrolls, %0d copying the screen back to word 0, over %0d register settings",
                 n_scrolls, n_copies, PHASES);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_writer.sv
verif/text_console_writer_test.sv
